[hw/rtl/quadratic_root_solver_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Clocked, reset-gated property checks used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define QRS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define QRS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qrs_pkg.sv]
// ---------------------------------------------------------------------------
// qrs_pkg
// Widths, codes and shared types of the quadratic root solver.
// ---------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int MAG_W   = COEF_WIDTH;
  localparam int PROD_W  = 2 * COEF_WIDTH;
  localparam int DISC_W  = 2 * COEF_WIDTH + 1;
  localparam int RAD_RAW = DISC_W + 2 * FRAC_BITS;
  localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int T1_W    = COEF_WIDTH + FRAC_BITS;
  localparam int NUM_W   = ROOT_W + 1;
  localparam int DEN_W   = COEF_WIDTH + 1;

  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (COEF_WIDTH - 1);
  localparam logic [NUM_W-1:0] POS_LIM = NEG_LIM - NUM_W'(1);
  localparam logic [COEF_WIDTH-1:0] SAT_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] SAT_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_TWO      = 2'd0,
    KIND_ONE      = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_NOT_QUAD = 2'd3
  } qrs_kind_t;

  // Values that ride alongside the square root.
  typedef struct packed {
    qrs_kind_t        kind;
    logic             an;
    logic [T1_W-1:0]  t1;
    logic             t1n;
    logic [DEN_W-1:0] den;
  } qrs_side_t;

  // Tag that rides alongside the divider lanes.
  typedef struct packed {
    qrs_kind_t kind;
    logic      an;
  } qrs_tag_t;

endpackage

[hw/rtl/qrs_front.sv]
// ---------------------------------------------------------------------------
// qrs_front
// Three stages: magnitudes, products, discriminant and classification.
// ---------------------------------------------------------------------------
module qrs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_v,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c,
  output logic                                 out_v,
  output logic [qrs_pkg::RAD_W-1:0]            out_rad,
  output qrs_pkg::qrs_side_t                   out_side
);

  localparam int W = qrs_pkg::COEF_WIDTH;

  logic [W-1:0] ua, ub, uc;
  logic [qrs_pkg::MAG_W-1:0] am_nxt, bm_nxt, cm_nxt;

  logic v1_r, v2_r, v3_r;
  logic [qrs_pkg::MAG_W-1:0] am1_r, bm1_r, cm1_r, am2_r, bm2_r;
  logic an1_r, bn1_r, cn1_r, az1_r, an2_r, bn2_r, cn2_r, az2_r;
  logic [qrs_pkg::PROD_W-1:0] bb_nxt, ac_nxt, bb_r, ac_r;

  logic [qrs_pkg::DISC_W-1:0] bbx, ac4, d_sum, d_dif, d_val;
  logic                       d_ge, opp;
  qrs_pkg::qrs_kind_t         kind_nxt;
  logic [qrs_pkg::RAD_W-1:0]  rad_r;
  qrs_pkg::qrs_side_t         side_nxt, side_r;

  assign ua = $unsigned(coef_a);
  assign ub = $unsigned(coef_b);
  assign uc = $unsigned(coef_c);
  assign am_nxt = ua[W-1] ? (~ua + W'(1)) : ua;
  assign bm_nxt = ub[W-1] ? (~ub + W'(1)) : ub;
  assign cm_nxt = uc[W-1] ? (~uc + W'(1)) : uc;

  assign bb_nxt = bm1_r * bm1_r;
  assign ac_nxt = am1_r * cm1_r;

  always_comb begin
    bbx   = qrs_pkg::DISC_W'(bb_r);
    ac4   = qrs_pkg::DISC_W'({ac_r, 2'b00});
    d_sum = bbx + ac4;
    d_dif = bbx - ac4;
    d_ge  = (bbx >= ac4);
    opp   = (an2_r != cn2_r);
    d_val = opp ? d_sum : d_dif;
    if (az2_r) begin
      kind_nxt = qrs_pkg::KIND_NOT_QUAD;
    end else if (!opp && !d_ge) begin
      kind_nxt = qrs_pkg::KIND_COMPLEX;
    end else if (d_val == '0) begin
      kind_nxt = qrs_pkg::KIND_ONE;
    end else begin
      kind_nxt = qrs_pkg::KIND_TWO;
    end
    side_nxt.kind = kind_nxt;
    side_nxt.an   = an2_r;
    side_nxt.t1   = qrs_pkg::T1_W'(bm2_r) << qrs_pkg::FRAC_BITS;
    side_nxt.t1n  = !bn2_r && (bm2_r != '0);
    side_nxt.den  = qrs_pkg::DEN_W'(am2_r) << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      am1_r  <= am_nxt;
      bm1_r  <= bm_nxt;
      cm1_r  <= cm_nxt;
      an1_r  <= ua[W-1];
      bn1_r  <= ub[W-1];
      cn1_r  <= uc[W-1];
      az1_r  <= (ua == '0);
      bb_r   <= bb_nxt;
      ac_r   <= ac_nxt;
      am2_r  <= am1_r;
      bm2_r  <= bm1_r;
      an2_r  <= an1_r;
      bn2_r  <= bn1_r;
      cn2_r  <= cn1_r;
      az2_r  <= az1_r;
      rad_r  <= qrs_pkg::RAD_W'(d_val) << (2 * qrs_pkg::FRAC_BITS);
      side_r <= side_nxt;
    end
  end

  assign out_v    = v3_r;
  assign out_rad  = rad_r;
  assign out_side = side_r;

endmodule

[hw/rtl/qrs_sqrt.sv]
// ---------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [qrs_pkg::RAD_W-1:0]  in_rad,
  input  qrs_pkg::qrs_side_t         in_side,
  output logic                       out_v,
  output logic [qrs_pkg::ROOT_W-1:0] out_root,
  output qrs_pkg::qrs_side_t         out_side
);

  localparam int N = qrs_pkg::ROOT_W;

  logic                       v_r    [N];
  logic [qrs_pkg::RAD_W-1:0]  rad_r  [N];
  logic [qrs_pkg::REM_W-1:0]  rem_r  [N];
  logic [qrs_pkg::ROOT_W-1:0] root_r [N];
  qrs_pkg::qrs_side_t         side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic                       v_in;
    logic [qrs_pkg::RAD_W-1:0]  rad_in;
    logic [qrs_pkg::REM_W-1:0]  rem_in;
    logic [qrs_pkg::ROOT_W-1:0] root_in;
    qrs_pkg::qrs_side_t         side_in;
    logic [qrs_pkg::REM_W+1:0]  rem_new, trial, diff;
    logic                       ge;

    if (i == 0) begin : g_first
      assign v_in    = in_v;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign rem_new = {rem_in, rad_in[qrs_pkg::RAD_W-1 -: 2]};
    assign trial   = (qrs_pkg::REM_W+2)'({root_in, 2'b01});
    assign diff    = rem_new - trial;
    assign ge      = (rem_new >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[i]  <= rad_in << 2;
        rem_r[i]  <= ge ? diff[qrs_pkg::REM_W-1:0] : rem_new[qrs_pkg::REM_W-1:0];
        root_r[i] <= {root_in[qrs_pkg::ROOT_W-2:0], ge};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_v    = v_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

[hw/rtl/qrs_div.sv]
// ---------------------------------------------------------------------------
// qrs_div
// Signed numerators -B*2^F +/- S, then two restoring divider lanes.
// ---------------------------------------------------------------------------
module qrs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [qrs_pkg::ROOT_W-1:0] in_root,
  input  qrs_pkg::qrs_side_t         in_side,
  output logic                       out_v,
  output qrs_pkg::qrs_tag_t          out_tag,
  output logic [qrs_pkg::NUM_W-1:0]  out_q   [2],
  output logic [qrs_pkg::DEN_W-1:0]  out_m   [2],
  output logic                       out_neg [2]
);

  localparam int N = qrs_pkg::NUM_W;

  logic [N-1:0] t1x, sx, nsum, ndif, np, nm;
  logic         nge, npn, nmn;

  logic                      cv_r;
  logic [N-1:0]              cnum_r [2];
  logic                      cneg_r [2];
  logic [qrs_pkg::DEN_W-1:0] cden_r;
  qrs_pkg::qrs_tag_t         ctag_r;

  logic                      v_r   [N];
  logic [qrs_pkg::DEN_W-1:0] den_r [N];
  qrs_pkg::qrs_tag_t         tag_r [N];
  logic [N-1:0]              nq_r  [N][2];
  logic [qrs_pkg::DEN_W-1:0] m_r   [N][2];
  logic                      neg_r [N][2];

  // Sign-magnitude sums: plus lane adds S, minus lane subtracts it.
  always_comb begin
    t1x  = N'(in_side.t1);
    sx   = N'(in_root);
    nsum = t1x + sx;
    nge  = (t1x >= sx);
    ndif = nge ? (t1x - sx) : (sx - t1x);
    np   = in_side.t1n ? ndif : nsum;
    npn  = in_side.t1n && nge;
    nm   = in_side.t1n ? nsum : ndif;
    nmn  = in_side.t1n || !nge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else if (adv) begin
      cv_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnum_r[0]   <= np;
      cnum_r[1]   <= nm;
      cneg_r[0]   <= (npn != in_side.an) && (np != '0);
      cneg_r[1]   <= (nmn != in_side.an) && (nm != '0);
      cden_r      <= in_side.den;
      ctag_r.kind <= in_side.kind;
      ctag_r.an   <= in_side.an;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic                      v_in;
    logic [qrs_pkg::DEN_W-1:0] den_in;
    qrs_pkg::qrs_tag_t         tag_in;

    if (i == 0) begin : g_first
      assign v_in   = cv_r;
      assign den_in = cden_r;
      assign tag_in = ctag_r;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[i] <= den_in;
        tag_r[i] <= tag_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [N-1:0]              nq_in;
      logic [qrs_pkg::DEN_W-1:0] m_in;
      logic                      neg_in;
      logic [qrs_pkg::DEN_W:0]   m_new, denx, diff;
      logic                      ge;

      if (i == 0) begin : g_first
        assign nq_in  = cnum_r[l];
        assign m_in   = '0;
        assign neg_in = cneg_r[l];
      end else begin : g_next
        assign nq_in  = nq_r[i-1][l];
        assign m_in   = m_r[i-1][l];
        assign neg_in = neg_r[i-1][l];
      end

      assign m_new = {m_in, nq_in[N-1]};
      assign denx  = (qrs_pkg::DEN_W+1)'(den_in);
      assign diff  = m_new - denx;
      assign ge    = (m_new >= denx);

      // Shift the numerator out at the top and the quotient in at the bottom.
      always_ff @(posedge clk) begin
        if (adv) begin
          nq_r[i][l]  <= {nq_in[N-2:0], ge};
          m_r[i][l]   <= ge ? diff[qrs_pkg::DEN_W-1:0] : m_new[qrs_pkg::DEN_W-1:0];
          neg_r[i][l] <= neg_in;
        end
      end
    end
  end

  assign out_v   = v_r[N-1];
  assign out_tag = tag_r[N-1];
  for (genvar l = 0; l < 2; l++) begin : g_out
    assign out_q[l]   = nq_r[N-1][l];
    assign out_m[l]   = m_r[N-1][l];
    assign out_neg[l] = neg_r[N-1][l];
  end

endmodule

[hw/rtl/qrs_out.sv]
// ---------------------------------------------------------------------------
// qrs_out
// Floor correction, clamping, root ordering, output register and skid.
// ---------------------------------------------------------------------------
module qrs_out (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_v,
  input  qrs_pkg::qrs_tag_t                    in_tag,
  input  logic [qrs_pkg::NUM_W-1:0]            in_q   [2],
  input  logic [qrs_pkg::DEN_W-1:0]            in_m   [2],
  input  logic                                 in_neg [2],
  output logic                                 skid_full,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_root_kind,
  output logic signed [qrs_pkg::COEF_WIDTH-1:0] out_root_first,
  output logic signed [qrs_pkg::COEF_WIDTH-1:0] out_root_second,
  output logic                                 out_saturated
);

  localparam int W = qrs_pkg::COEF_WIDTH;

  typedef struct packed {
    qrs_pkg::qrs_kind_t kind;
    logic [W-1:0]       first;
    logic [W-1:0]       second;
    logic               sat;
  } res_t;

  logic                      adv;
  logic                      va_r;
  logic [qrs_pkg::NUM_W-1:0] qf_r  [2];
  logic                      neg_r [2];
  qrs_pkg::qrs_tag_t         tag_r;

  logic [W-1:0] lane_val [2];
  logic         lane_sat [2];
  res_t         res_nxt, res_r, skid_r;
  logic         ov_r, sv_r, take;

  assign adv  = !sv_r;
  assign take = ov_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_v;
    end
  end

  // Round toward minus infinity: bump a negative quotient with a remainder.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        qf_r[l]  <= in_q[l] + qrs_pkg::NUM_W'(in_neg[l] && (in_m[l] != '0));
        neg_r[l] <= in_neg[l];
      end
      tag_r <= in_tag;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_r[l]) begin
        lane_sat[l] = (qf_r[l] > qrs_pkg::NEG_LIM);
        lane_val[l] = lane_sat[l] ? qrs_pkg::SAT_MIN : (~qf_r[l][W-1:0] + W'(1));
      end else begin
        lane_sat[l] = (qf_r[l] > qrs_pkg::POS_LIM);
        lane_val[l] = lane_sat[l] ? qrs_pkg::SAT_MAX : qf_r[l][W-1:0];
      end
    end
    res_nxt.kind = tag_r.kind;
    case (tag_r.kind)
      qrs_pkg::KIND_TWO: begin
        res_nxt.first  = tag_r.an ? lane_val[1] : lane_val[0];
        res_nxt.second = tag_r.an ? lane_val[0] : lane_val[1];
        res_nxt.sat    = lane_sat[0] || lane_sat[1];
      end
      qrs_pkg::KIND_ONE: begin
        res_nxt.first  = lane_val[0];
        res_nxt.second = '0;
        res_nxt.sat    = lane_sat[0];
      end
      default: begin
        res_nxt.first  = '0;
        res_nxt.second = '0;
        res_nxt.sat    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (take) begin
        sv_r <= 1'b0;
      end
    end else if (va_r) begin
      if (ov_r && !take) begin
        sv_r <= 1'b1;
      end else begin
        ov_r <= 1'b1;
      end
    end else if (take) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (take) begin
        res_r <= skid_r;
      end
    end else if (va_r) begin
      if (ov_r && !take) begin
        skid_r <= res_nxt;
      end else begin
        res_r <= res_nxt;
      end
    end
  end

  assign skid_full       = sv_r;
  assign out_valid       = ov_r;
  assign out_root_kind   = res_r.kind;
  assign out_root_first  = $signed(res_r.first);
  assign out_root_second = $signed(res_r.second);
  assign out_saturated   = res_r.sat;

endmodule

[hw/rtl/quadratic_root_solver.sv]
// ---------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in_      | input     | in_valid / in_stall  | coef_a, coef_b, coef_c
//  out_     | output    | out_valid / out_stall| root_kind, root_first,
//           |           |                      | root_second, saturated
//
//  One coefficient set per cycle while in_stall is low. The pipe holds the root pipe
//  (ROOT_W = 49 stages) and the two divider lanes (NUM_W = 50 stages).
//  Front end takes 3 stages, numerator build 1, floor fix 1, output reg 1.
//  Reset (rst_n low, synchronous) clears only valid bits and the skid.
//  The whole pipe advances while the skid is empty; a stalled result parks
//  in the skid, which raises in_stall until the next output transfer.
// ---------------------------------------------------------------------------
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0] in_coef_c,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_root_kind,
  output logic signed [qrs_pkg::COEF_WIDTH-1:0] out_root_first,
  output logic signed [qrs_pkg::COEF_WIDTH-1:0] out_root_second,
  output logic                                 out_saturated
);

  // Global advance: every stage before the output register moves together while the skid has room.
  logic adv;
  logic skid_full;

  logic                       f_v;
  logic [qrs_pkg::RAD_W-1:0]  f_rad;
  qrs_pkg::qrs_side_t         f_side;

  logic                       s_v;
  logic [qrs_pkg::ROOT_W-1:0] s_root;
  qrs_pkg::qrs_side_t         s_side;

  logic                       d_v;
  qrs_pkg::qrs_tag_t          d_tag;
  logic [qrs_pkg::NUM_W-1:0]  d_q   [2];
  logic [qrs_pkg::DEN_W-1:0]  d_m   [2];
  logic                       d_neg [2];

  assign adv      = !skid_full;
  assign in_stall = skid_full;

  // Magnitudes, B*B and A*C, then discriminant and equation class.
  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .coef_a   (in_coef_a),
    .coef_b   (in_coef_b),
    .coef_c   (in_coef_c),
    .out_v    (f_v),
    .out_rad  (f_rad),
    .out_side (f_side)
  );

  // S = floor(sqrt(D * 2^(2F))); a zero discriminant gives S = 0.
  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (f_v),
    .in_rad   (f_rad),
    .in_side  (f_side),
    .out_v    (s_v),
    .out_root (s_root),
    .out_side (s_side)
  );

  // Lane 0 divides -B*2^F + S, lane 1 divides -B*2^F - S, both by 2A.
  qrs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (s_v),
    .in_root (s_root),
    .in_side (s_side),
    .out_v   (d_v),
    .out_tag (d_tag),
    .out_q   (d_q),
    .out_m   (d_m),
    .out_neg (d_neg)
  );

  // Floor, clamp, put the greater root first, hold the result for transfer.
  qrs_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_v            (d_v),
    .in_tag          (d_tag),
    .in_q            (d_q),
    .in_m            (d_m),
    .in_neg          (d_neg),
    .skid_full       (skid_full),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_root_kind   (out_root_kind),
    .out_root_first  (out_root_first),
    .out_root_second (out_root_second),
    .out_saturated   (out_saturated)
  );

  // A full skid always sits behind a full output register.
  `QRS_CHECK(a_skid_behind_out, in_stall, out_valid, "skid full with output empty")
  // A full skid drains on the output transfer.
  `QRS_CHECK_NEXT(a_skid_drain, in_stall && !out_stall, !in_stall, "skid did not drain")
  // No real root: both roots and the saturated flag read zero.
  `QRS_CHECK(a_no_root_zero,
    out_valid && (out_root_kind == qrs_pkg::KIND_COMPLEX ||
                  out_root_kind == qrs_pkg::KIND_NOT_QUAD),
    out_root_first == '0 && out_root_second == '0 && !out_saturated,
    "nonzero roots without a real root")
  // Repeated root: second root reads zero.
  `QRS_CHECK(a_one_root_second,
    out_valid && out_root_kind == qrs_pkg::KIND_ONE,
    out_root_second == '0, "second root set for repeated root")

endmodule
